/* rtl/pid_controller_clamped_defines.svh */
// Assertion macros shared by the checker of the PID controller
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIDC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pidc_pkg.sv */
// Shared widths, register codes and stage types of the PID controller
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIM_W     = 31;
  localparam int ERR_W     = DATA_W + 1;
  localparam int DIFF_W    = DATA_W + 2;
  localparam int SUM_W     = DATA_W;
  localparam int RAW_W     = ERR_W + 1;
  localparam int PROD_W    = DATA_W + DIFF_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + 2;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic ACT_CALC  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_SUM_LIMIT  = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_DRIVE_MIN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic        [LIM_W-1:0]  sum_limit;
    logic signed [DATA_W-1:0] drive_max;
    logic signed [DATA_W-1:0] drive_min;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } err_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
  } term_item_t;

endpackage

/* rtl/pidc_cfg_regs.sv */
// APB register file holding gains, sum limit and drive bounds
module pidc_cfg_regs
  import pidc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_nxt.prop_gain  = pwdata;
        REG_INTEG_GAIN: cfg_nxt.integ_gain = pwdata;
        REG_DERIV_GAIN: cfg_nxt.deriv_gain = pwdata;
        REG_SUM_LIMIT:  cfg_nxt.sum_limit  = pwdata[LIM_W-1:0];
        REG_DRIVE_MAX:  cfg_nxt.drive_max  = pwdata;
        REG_DRIVE_MIN:  cfg_nxt.drive_min  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:  prdata = cfg_r.prop_gain;
      REG_INTEG_GAIN: prdata = cfg_r.integ_gain;
      REG_DERIV_GAIN: prdata = cfg_r.deriv_gain;
      REG_SUM_LIMIT:  prdata = DATA_W'(cfg_r.sum_limit);
      REG_DRIVE_MAX:  prdata = cfg_r.drive_max;
      REG_DRIVE_MIN:  prdata = cfg_r.drive_min;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/pidc_err_stage.sv */
// Input register, error, clamped integrator and last-error state
module pidc_err_stage
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic signed [DATA_W-1:0] in_measured,
  input  logic        [LIM_W-1:0]  sum_limit,
  output logic                     dn_valid,
  output err_item_t                dn_item,
  input  logic                     dn_ready
);

  logic                     in_v_r;
  logic                     act_r;
  logic signed [DATA_W-1:0] tgt_r;
  logic signed [DATA_W-1:0] meas_r;

  logic signed [SUM_W-1:0]  err_sum_r;
  logic signed [SUM_W-1:0]  err_sum_nxt;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  prev_err_nxt;

  logic                     item_v_r;
  err_item_t                item_r;

  logic                     rdy0;
  logic                     rdy1;
  logic                     move;
  logic signed [ERR_W-1:0]  err;
  logic signed [RAW_W-1:0]  sum_raw;
  logic signed [RAW_W-1:0]  lim_pos;
  logic signed [RAW_W-1:0]  lim_neg;
  logic signed [RAW_W-1:0]  sum_c;
  logic signed [DIFF_W-1:0] diff;

  assign rdy1     = !item_v_r || dn_ready;
  assign rdy0     = !in_v_r || rdy1;
  assign in_stall = !rdy0;
  assign move     = in_v_r && rdy1;
  assign dn_valid = item_v_r;
  assign dn_item  = item_r;

  assign err     = ERR_W'(tgt_r) - ERR_W'(meas_r);
  assign sum_raw = RAW_W'(err_sum_r) + RAW_W'(err);
  assign lim_pos = RAW_W'(signed'({1'b0, sum_limit}));
  assign lim_neg = -lim_pos;
  assign diff    = DIFF_W'(err) - DIFF_W'(prev_err_r);

  always_comb begin
    priority if (sum_raw > lim_pos) begin
      sum_c = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_c = lim_neg;
    end else begin
      sum_c = sum_raw;
    end
  end

  always_comb begin
    err_sum_nxt  = err_sum_r;
    prev_err_nxt = prev_err_r;
    if (move) begin
      if (act_r == ACT_CLEAR) begin
        err_sum_nxt  = '0;
        prev_err_nxt = '0;
      end else begin
        err_sum_nxt  = sum_c[SUM_W-1:0];
        prev_err_nxt = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      item_v_r   <= 1'b0;
      err_sum_r  <= '0;
      prev_err_r <= '0;
    end else begin
      err_sum_r  <= err_sum_nxt;
      prev_err_r <= prev_err_nxt;
      if (rdy0) begin
        in_v_r <= in_valid;
      end
      if (rdy1) begin
        item_v_r <= move && (act_r == ACT_CALC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      act_r  <= in_action;
      tgt_r  <= in_target;
      meas_r <= in_measured;
    end
    if (move) begin
      item_r.err  <= err;
      item_r.sum  <= sum_c[SUM_W-1:0];
      item_r.diff <= diff;
    end
  end

endmodule

/* rtl/pidc_mul_stage.sv */
// Gain products, floor-shifted to terms and registered
module pidc_mul_stage
  import pidc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       up_valid,
  input  err_item_t  up_item,
  output logic       up_ready,
  output logic       dn_valid,
  output term_item_t dn_item,
  input  logic       dn_ready
);

  logic                     v_r;
  term_item_t               item_r;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0] d_prod;
  logic signed [PROD_W-1:0] p_sh;
  logic signed [PROD_W-1:0] i_sh;
  logic signed [PROD_W-1:0] d_sh;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  assign p_prod = PROD_W'(cfg.prop_gain)  * PROD_W'(up_item.err);
  assign i_prod = PROD_W'(cfg.integ_gain) * PROD_W'(up_item.sum);
  assign d_prod = PROD_W'(cfg.deriv_gain) * PROD_W'(up_item.diff);

  // arithmetic shift gives floor rounding
  assign p_sh = p_prod >>> FRAC_BITS;
  assign i_sh = i_prod >>> FRAC_BITS;
  assign d_sh = d_prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r.p_term <= p_sh[TERM_W-1:0];
      item_r.i_term <= i_sh[TERM_W-1:0];
      item_r.d_term <= d_sh[TERM_W-1:0];
    end
  end

endmodule

/* rtl/pidc_out_stage.sv */
// Term sum, drive clamp and result register
module pidc_out_stage
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     up_valid,
  input  term_item_t               up_item,
  output logic                     up_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_drive
);

  logic                     out_v_r;
  logic signed [DATA_W-1:0] drive_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  hi;
  logic signed [ACC_W-1:0]  lo;
  logic signed [ACC_W-1:0]  drive_c;

  assign up_ready  = !out_v_r || !out_stall;
  assign out_valid = out_v_r;
  assign out_drive = drive_r;

  assign acc = ACC_W'(up_item.p_term) + ACC_W'(up_item.i_term) + ACC_W'(up_item.d_term);
  assign hi  = ACC_W'(cfg.drive_max);
  assign lo  = ACC_W'(cfg.drive_min);

  // upper bound first, lower bound wins when the bounds cross
  always_comb begin
    drive_c = acc;
    if (drive_c > hi) begin
      drive_c = hi;
    end
    if (drive_c < lo) begin
      drive_c = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (up_ready) begin
      out_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      drive_r <= drive_c[DATA_W-1:0];
    end
  end

endmodule

/* rtl/pid_controller_clamped.sv */
// Top level of the clamped positional PID controller
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    in_action, in_target, in_measured
//   out      source     out_valid/out_stall  out_drive
//   cfg      APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// A calculate item gives one drive; one item per cycle while no stall holds it.
// The pipeline is input register, error/integrator, products, sum and clamp.
// A clear item updates the state in the error stage and leaves no result.
// Stalls propagate stage by stage; empty stages keep taking items.
// Synchronous active-low reset clears state, config registers and valid flags.
module pid_controller_clamped
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic signed [DATA_W-1:0] in_measured,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_drive,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  cfg_t       cfg;
  logic       e_valid;
  err_item_t  e_item;
  logic       m_ready;
  logic       m_valid;
  term_item_t m_item;
  logic       o_ready;

  pidc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidc_err_stage u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_target   (in_target),
    .in_measured (in_measured),
    .sum_limit   (cfg.sum_limit),
    .dn_valid    (e_valid),
    .dn_item     (e_item),
    .dn_ready    (m_ready)
  );

  pidc_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (e_valid),
    .up_item  (e_item),
    .up_ready (m_ready),
    .dn_valid (m_valid),
    .dn_item  (m_item),
    .dn_ready (o_ready)
  );

  pidc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (m_valid),
    .up_item   (m_item),
    .up_ready  (o_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_drive (out_drive)
  );

endmodule

/* rtl/pidc_checker.sv */
// Port-level checker for the PID controller and its bind
`include "pid_controller_clamped_defines.svh"

module pidc_checker
  import pidc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_drive,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [ADDR_W-1:0]        paddr,
  input logic [DATA_W-1:0]        pwdata,
  input logic [DATA_W-1:0]        prdata,
  input logic                     pready
);

  logic              wr_acc;
  logic              rd_acc;
  logic [IDX_W-1:0]  rd_idx;
  logic              word_idx;
  logic              lim_idx;
  logic              rd_after_wr;
  logic              wr_q_r;
  logic [ADDR_W-1:0] paddr_q_r;
  logic [DATA_W-1:0] pwdata_q_r;

  assign wr_acc      = psel && penable && pwrite && pready;
  assign rd_acc      = psel && penable && !pwrite;
  assign rd_idx      = paddr[ADDR_W-1:2];
  assign word_idx    = (rd_idx == REG_PROP_GAIN) || (rd_idx == REG_INTEG_GAIN) ||
                       (rd_idx == REG_DERIV_GAIN) || (rd_idx == REG_DRIVE_MAX) ||
                       (rd_idx == REG_DRIVE_MIN);
  assign lim_idx     = (rd_idx == REG_SUM_LIMIT);
  assign rd_after_wr = rd_acc && wr_q_r && (paddr == paddr_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_q_r <= 1'b0;
    end else begin
      wr_q_r <= wr_acc;
    end
  end

  always_ff @(posedge clk) begin
    paddr_q_r  <= paddr;
    pwdata_q_r <= pwdata;
  end

  `PIDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_drive), "stalled result item changed")

  `PIDC_ASSERT(a_drained_accepts, !out_valid || !out_stall, !in_stall, "input stalled while output moves")

  `PIDC_ASSERT(a_readback_word, rd_after_wr && word_idx, prdata == pwdata_q_r, "read back differs from write")

  `PIDC_ASSERT(a_readback_limit, rd_after_wr && lim_idx, prdata == {1'b0, pwdata_q_r[LIM_W-1:0]}, "sum limit read back differs")

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);

/* dv/pid_controller_clamped_tb.sv */
// Self-checking testbench of the clamped positional PID controller
`timescale 1ns / 100ps

import pidc_pkg::*;

typedef logic signed [69:0] acc_wide_t;

class pid_scoreboard;
  cfg_t                     shadow;
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [DATA_W-1:0] expected_drives[$];
  int                       errors;

  function new();
    shadow   = '0;
    err_sum  = '0;
    last_err = '0;
    errors   = 0;
  endfunction

  function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_PROP_GAIN: begin
        shadow.prop_gain = value;
      end
      REG_INTEG_GAIN: begin
        shadow.integ_gain = value;
      end
      REG_DERIV_GAIN: begin
        shadow.deriv_gain = value;
      end
      REG_SUM_LIMIT: begin
        shadow.sum_limit = value[LIM_W-1:0];
      end
      REG_DRIVE_MAX: begin
        shadow.drive_max = value;
      end
      REG_DRIVE_MIN: begin
        shadow.drive_min = value;
      end
      default: begin
      end
    endcase
  endfunction

  // exact product, then floor shift by the fraction width
  function acc_wide_t floor_scale(acc_wide_t a, acc_wide_t b);
    acc_wide_t p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function void note_sample(logic act, logic signed [DATA_W-1:0] tgt,
                            logic signed [DATA_W-1:0] meas);
    acc_wide_t e, m, s, lim, kp, ki, kd, prev, hi, lo, d;
    if (act == ACT_CLEAR) begin
      err_sum  = '0;
      last_err = '0;
      return;
    end
    e    = $signed(tgt);
    m    = $signed(meas);
    e    = e - m;
    s    = $signed(err_sum);
    s    = s + e;
    lim  = shadow.sum_limit;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    err_sum = s[SUM_W-1:0];
    kp   = $signed(shadow.prop_gain);
    ki   = $signed(shadow.integ_gain);
    kd   = $signed(shadow.deriv_gain);
    prev = $signed(last_err);
    d    = floor_scale(kp, e) + floor_scale(ki, s) + floor_scale(kd, e - prev);
    last_err = e[ERR_W-1:0];
    hi   = $signed(shadow.drive_max);
    lo   = $signed(shadow.drive_min);
    if (d > hi) d = hi;
    if (d < lo) d = lo;
    expected_drives.push_back(d[DATA_W-1:0]);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_drive(logic signed [DATA_W-1:0] got);
    logic signed [DATA_W-1:0] want;
    if (expected_drives.size() == 0) begin
      report($sformatf("drive %0d with no item outstanding", got));
    end else begin
      want = expected_drives.pop_front();
      if (got !== want) report($sformatf("drive %0d, expected %0d", got, want));
    end
  endtask

  function int pending();
    return expected_drives.size();
  endfunction
endclass

module pid_controller_clamped_tb;

  localparam int LIMIT = 400000;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh80000000;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_action = ACT_CALC;
  logic signed [DATA_W-1:0] in_target = '0;
  logic signed [DATA_W-1:0] in_measured = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_drive;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  pid_scoreboard board = new();
  int            cycles = 0;
  bit            no_idle = 1'b0;

  pid_controller_clamped i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_target  (in_target),
    .in_measured(in_measured),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_drive  (out_drive),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function logic signed [DATA_W-1:0] modest_gain();
    return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
  endfunction

  // result side: sample at the falling edge, take the item at the next rising edge
  initial begin
    logic signed [DATA_W-1:0] seen;
    int                       hold;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen = out_drive;
        @(posedge clk);
        board.check_drive(seen);
        hold = draw_wait();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // entered and left at a rising edge; valid stays up when the next item has no gap
  task send_item(logic act, logic signed [DATA_W-1:0] tgt, logic signed [DATA_W-1:0] meas);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_target   <= tgt;
    in_measured <= meas;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    board.note_sample(act, tgt, meas);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    board.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task configure(logic signed [DATA_W-1:0] kp, logic signed [DATA_W-1:0] ki,
                 logic signed [DATA_W-1:0] kd, logic [DATA_W-1:0] lim,
                 logic signed [DATA_W-1:0] hi, logic signed [DATA_W-1:0] lo);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_SUM_LIMIT, lim);
    write_reg(REG_DRIVE_MAX, hi);
    write_reg(REG_DRIVE_MIN, lo);
  endtask

  // clear items leave nothing to wait for, so allow the pipeline to drain too
  task wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic signed [DATA_W-1:0] tgt, meas, lo, hi;
    logic                     act;
    int                       shape;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: every drive is zero
    send_item(ACT_CALC, 32'sd100, -32'sd5);
    send_item(ACT_CALC, S_MAX, S_MIN);
    wait_idle();
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_item(ACT_CALC, S_MIN, S_MAX);
    wait_idle();

    configure(32'sh10000, 32'sh8000, 32'sh4000, 32'h7FFFFFFF, S_MAX, S_MIN);
    send_item(ACT_CALC, '0, '0);
    send_item(ACT_CALC, S_MAX, S_MIN);
    send_item(ACT_CALC, S_MAX, S_MIN);
    send_item(ACT_CALC, S_MIN, S_MAX);
    send_item(ACT_CALC, S_MIN, S_MAX);
    send_item(ACT_CALC, S_MAX, S_MAX);
    send_item(ACT_CALC, S_MIN, S_MIN);
    send_item(ACT_CLEAR, $urandom, $urandom);
    send_item(ACT_CALC, 32'sd1, 32'sd0);
    send_item(ACT_CALC, 32'sd0, 32'sd1);
    send_item(ACT_CALC, -32'sd1, S_MAX);
    send_item(ACT_CLEAR, S_MAX, S_MIN);
    send_item(ACT_CALC, 32'sh12345, 32'sd0);
    wait_idle();

    // extreme gains, zero sum limit, crossed bounds
    configure(S_MAX, S_MIN, S_MAX, '0, 32'sh100, 32'sh200);
    send_item(ACT_CALC, S_MAX, S_MIN);
    send_item(ACT_CALC, S_MIN, S_MAX);
    send_item(ACT_CALC, 32'sd5, 32'sd3);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      no_idle = (p == 2 || p == 6);
      hi = $signed($urandom_range(0, 32'h7FFFFFFF));
      lo = -$signed($urandom_range(0, 32'h7FFFFFFF));
      case (p)
        0: configure(modest_gain(), modest_gain(), modest_gain(), $urandom, hi, lo);
        1: configure(S_MAX, S_MAX, S_MAX, 32'h7FFFFFFF, S_MAX, S_MIN);
        2: configure(S_MIN, S_MIN, S_MIN, $urandom, S_MAX, S_MIN);
        3: configure(modest_gain(), modest_gain(), modest_gain(), $urandom, lo, hi);
        4: configure(modest_gain(), modest_gain(), modest_gain(), '0, hi, lo);
        5: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: configure(modest_gain(), modest_gain(), modest_gain(),
                           $urandom_range(0, 32'h00FFFFFF), hi, lo);
      endcase
      for (int n = 0; n < 100; n++) begin
        act   = ($urandom_range(0, 11) == 0) ? ACT_CLEAR : ACT_CALC;
        shape = $urandom_range(0, 3);
        tgt   = $urandom;
        meas  = $urandom;
        case (shape)
          1: meas = tgt + ($signed($urandom_range(0, 8192)) - 32'sd4096);
          2: begin
            tgt  = ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
            meas = ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
          end
          3: begin
            tgt  = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
            meas = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
          end
          default: begin
          end
        endcase
        send_item(act, tgt, meas);
      end
    end

    wait_idle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
